[rtl/toc_pkg.sv]
package toc_pkg;

  // Tour storage depth and the widths that follow from it.
  localparam int MAX_LEN = 64;
  localparam int CITY_W  = 6;
  localparam int SEG_W   = 6;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int CMP_W   = (CNT_W > SEG_W) ? CNT_W : SEG_W;
  localparam int NUM_CITIES = 1 << CITY_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BUILD,
    S_ISSUE,
    S_WAIT_A,
    S_WAIT_B,
    S_SHORT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic bm_rd;
    logic rd_a_pos;
    logic rd_b;
    logic out_a;
    logic out_b;
    logic out_short;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic seg_valid;
    logic bm_last;
    logic pos_in_seg;
    logic fptr_end;
    logic pos_last;
    logic b_hit;
    logic out_free;
  } status_t;

endpackage

[rtl/toc_ctrl.sv]
module toc_ctrl
  import toc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    final_element,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_valid && final_element) begin
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        if (!status.seg_valid || status.bm_last) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (status.pos_in_seg) begin
          state_next = S_WAIT_A;
        end else if (status.fptr_end) begin
          state_next = S_SHORT;
        end else begin
          state_next = S_WAIT_B;
        end
      end
      S_WAIT_A, S_SHORT: begin
        if (status.out_free) begin
          state_next = status.pos_last ? S_LOAD : S_ISSUE;
        end
      end
      S_WAIT_B: begin
        if (status.b_hit) begin
          state_next = S_ISSUE;
        end else if (status.out_free) begin
          state_next = status.pos_last ? S_LOAD : S_ISSUE;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.start = in_valid && final_element;
      end
      S_BUILD: begin
        cmd.bm_rd = status.seg_valid;
      end
      S_ISSUE: begin
        cmd.rd_a_pos = status.pos_in_seg;
        cmd.rd_b     = !status.pos_in_seg && !status.fptr_end;
      end
      S_WAIT_A: begin
        cmd.out_a  = status.out_free;
        cmd.finish = status.out_free && status.pos_last;
      end
      S_WAIT_B: begin
        cmd.out_b  = !status.b_hit && status.out_free;
        cmd.finish = !status.b_hit && status.out_free && status.pos_last;
      end
      S_SHORT: begin
        cmd.out_short = status.out_free;
        cmd.finish    = status.out_free && status.pos_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/toc_datapath.sv]
module toc_datapath
  import toc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [CITY_W-1:0] parent_a_city,
  input  logic [CITY_W-1:0] parent_b_city,
  input  logic [SEG_W-1:0]  segment_begin,
  input  logic [SEG_W-1:0]  segment_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CITY_W-1:0] child_city,
  output logic              child_last,
  output logic              fill_short
);

  logic [CITY_W-1:0] mem_a [MAX_LEN];
  logic [CITY_W-1:0] mem_b [MAX_LEN];

  logic [CNT_W-1:0]      len;
  logic [CNT_W-1:0]      fptr;
  logic [ADDR_W-1:0]     pos;
  logic [ADDR_W-1:0]     bm_idx;
  logic [ADDR_W-1:0]     seg_lo;
  logic [ADDR_W-1:0]     seg_hi;
  logic                  seg_valid;
  logic [NUM_CITIES-1:0] bitmap;
  logic                  bm_pend;
  logic [CITY_W-1:0]     a_data;
  logic [CITY_W-1:0]     b_data;

  logic                  has_room;
  logic [CNT_W-1:0]      n_new;
  logic [CNT_W-1:0]      last_idx;
  logic [CMP_W-1:0]      lo_ext;
  logic [CMP_W-1:0]      hi_ext;
  logic [CMP_W-1:0]      last_ext;
  logic [CMP_W-1:0]      hi_clamp;
  logic                  valid_new;
  logic [ADDR_W-1:0]     a_addr;
  logic                  any_out;

  assign has_room  = len < CNT_W'(MAX_LEN);
  assign n_new     = has_room ? len + CNT_W'(1) : len;
  assign last_idx  = n_new - CNT_W'(1);
  assign lo_ext    = CMP_W'(segment_begin);
  assign hi_ext    = CMP_W'(segment_end);
  assign last_ext  = CMP_W'(last_idx);
  assign hi_clamp  = (hi_ext > last_ext) ? last_ext : hi_ext;
  assign valid_new = (lo_ext <= hi_clamp) && (lo_ext < CMP_W'(n_new));
  assign a_addr    = cmd.bm_rd ? bm_idx : pos;
  assign any_out   = cmd.out_a || cmd.out_b || cmd.out_short;

  // Tour stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem_a[len[ADDR_W-1:0]] <= parent_a_city;
      mem_b[len[ADDR_W-1:0]] <= parent_b_city;
    end
    if (cmd.bm_rd || cmd.rd_a_pos) begin
      a_data <= mem_a[a_addr];
    end
    if (cmd.rd_b) begin
      b_data <= mem_b[fptr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      bm_pend <= 1'b0;
    end else begin
      bm_pend <= cmd.bm_rd;
      if (cmd.finish) begin
        len <= '0;
      end else if (cmd.load) begin
        len <= n_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      seg_lo    <= lo_ext[ADDR_W-1:0];
      seg_hi    <= hi_clamp[ADDR_W-1:0];
      seg_valid <= valid_new;
      bm_idx    <= lo_ext[ADDR_W-1:0];
      bitmap    <= '0;
      fptr      <= '0;
      pos       <= '0;
    end else begin
      if (cmd.bm_rd) begin
        bm_idx <= bm_idx + ADDR_W'(1);
      end
      if (bm_pend) begin
        bitmap[a_data] <= 1'b1;
      end
      if (cmd.rd_b) begin
        fptr <= fptr + CNT_W'(1);
      end
      if (any_out) begin
        pos <= pos + ADDR_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (any_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (any_out) begin
      child_last <= status.pos_last;
      fill_short <= cmd.out_short;
      if (cmd.out_a) begin
        child_city <= a_data;
      end else if (cmd.out_b) begin
        child_city <= b_data;
      end else begin
        child_city <= '0;
      end
    end
  end

  assign status.seg_valid  = seg_valid;
  assign status.bm_last    = bm_idx == seg_hi;
  assign status.pos_in_seg = seg_valid && (pos >= seg_lo) && (pos <= seg_hi);
  assign status.fptr_end   = fptr == len;
  assign status.pos_last   = (CNT_W'(pos) + CNT_W'(1)) == len;
  assign status.b_hit      = bitmap[b_data];
  assign status.out_free   = !out_valid || out_ready;

endmodule

[rtl/tour_order_crossover_unit.sv]
// While loading, in_ready is high and every input transfer is taken; a non-final position
// gives no result. After the final transfer the unit reads parent A at each kept segment
// position to build the segment city set. It then produces each child position from a read
// of parent A or parent B, or as a short fill, with an output step that waits while the
// output register is full; each skipped parent B entry takes a further read through its single read port.
// Synchronous active-high reset returns the controller to loading; stores are not cleared.
module tour_order_crossover_unit
  import toc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CITY_W-1:0] parent_a_city,
  input  logic [CITY_W-1:0] parent_b_city,
  input  logic [SEG_W-1:0]  segment_begin,
  input  logic [SEG_W-1:0]  segment_end,
  input  logic              final_element,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CITY_W-1:0] child_city,
  output logic              child_last,
  output logic              fill_short
);

  // The controller sequences the job: it takes input transfers while loading, walks the
  // kept segment of parent A to mark its cities, and then produces the child one position
  // at a time, scanning parent B for the next city outside the segment when needed.
  cmd_t    cmd;
  status_t status;

  toc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .final_element (final_element),
    .status        (status),
    .cmd           (cmd)
  );

  // The datapath holds both tour stores, the segment city set, the position and fill
  // pointers, and the output register. The output register lets a new job load while the
  // last child position is still waiting for its transfer.
  toc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .parent_a_city (parent_a_city),
    .parent_b_city (parent_b_city),
    .segment_begin (segment_begin),
    .segment_end   (segment_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .child_city    (child_city),
    .child_last    (child_last),
    .fill_short    (fill_short)
  );

endmodule

[rtl/toc_checker.sv]
module toc_checker
  import toc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              final_element,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CITY_W-1:0] child_city,
  input logic              child_last,
  input logic              fill_short
);

  // A short fill always carries city zero.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fill_short |-> child_city == '0)
    else $error("fill_short result with nonzero city");

  // The unit stops taking input once the final position has been taken.
  a_busy_after_final: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && final_element |=> !in_ready)
    else $error("input taken right after final position");

  // No result appears right after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(child_city) &&
      $stable(child_last) && $stable(fill_short))
    else $error("stalled result changed");

endmodule

bind tour_order_crossover_unit toc_checker u_toc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .final_element (final_element),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .child_city    (child_city),
  .child_last    (child_last),
  .fill_short    (fill_short)
);
